// ----- rtl/rrc_pkg.sv -----
// Shared types and constants for the row reservation conflict check unit.
// No dependencies; imported by the controller, datapath and top level.
package rrc_pkg;

    localparam int ROWS_DEF    = 1024;
    localparam int ID_BITS_DEF = 32;

    localparam int CMD_W = 2;
    localparam int ROW_W = 10;
    localparam int TXN_W = 32;

    // pass codes carried on the command port
    localparam logic [CMD_W-1:0] CMD_RESERVE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CHECK   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd2;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_EXEC
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic clear;   // write free value at the clear counter
        logic load;    // capture a new access
        logic lookup;  // table read at the reduced row
        logic exec;    // update tables and flags, issue result
    } ctl_t;

    // datapath -> controller
    typedef struct packed {
        logic clr_last;
    } sts_t;

endpackage

// ----- rtl/rrc_ctrl.sv -----
// Sequencing state machine for the row reservation conflict check unit.
// Depends on rrc_pkg for state_t, ctl_t and sts_t.
module rrc_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  rrc_pkg::sts_t sts,
    output rrc_pkg::ctl_t ctl,
    output logic          busy
);
    import rrc_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (sts.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP: state_next = ST_EXEC;
            ST_EXEC:   state_next = ST_IDLE;
            default:   state_next = ST_CLEAR;
        endcase
    end

    always_comb
    begin
        ctl  = '0;
        busy = 1'b1;
        case (state_reg)
            ST_CLEAR:  ctl.clear = 1'b1;
            ST_IDLE:
            begin
                busy     = 1'b0;
                ctl.load = start;
            end
            ST_LOOKUP: ctl.lookup = 1'b1;
            ST_EXEC:   ctl.exec = 1'b1;
            default:   busy = 1'b1;
        endcase
    end

endmodule

// ----- rtl/rrc_datapath.sv -----
// Reservation tables, hazard flags and result registers.
// Depends on rrc_pkg; driven by rrc_ctrl through ctl_t / sts_t.
module rrc_datapath #(
    parameter int ROWS    = rrc_pkg::ROWS_DEF,
    parameter int ID_BITS = rrc_pkg::ID_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  rrc_pkg::ctl_t             ctl,
    output rrc_pkg::sts_t             sts,
    input  logic [rrc_pkg::CMD_W-1:0] command,
    input  logic [rrc_pkg::ROW_W-1:0] row_index,
    input  logic                      is_write,
    input  logic [rrc_pkg::TXN_W-1:0] txn_id,
    input  logic                      first_access,
    input  logic                      last_access,
    output logic                      done,
    output logic                      aborted,
    output logic                      war_found,
    output logic                      raw_found,
    output logic                      pass_done
);
    import rrc_pkg::*;

    localparam int IDX_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam logic [ID_BITS-1:0] FREE_ID = '1;

    logic [ID_BITS-1:0] writer_mem [ROWS];
    logic [ID_BITS-1:0] reader_mem [ROWS];

    logic [CMD_W-1:0]   cmd_reg;
    logic [ROW_W-1:0]   row_reg;
    logic               wr_reg;
    logic [ID_BITS-1:0] id_reg;
    logic               first_reg;
    logic               last_reg;

    logic [IDX_W-1:0]   clr_cnt_reg;
    logic [IDX_W-1:0]   row_red;
    logic [IDX_W-1:0]   addr_reg;
    logic [ID_BITS-1:0] wr_rd_reg;
    logic [ID_BITS-1:0] rd_rd_reg;

    logic               abort_reg;
    logic               war_reg;
    logic               raw_reg;
    logic               done_reg;
    logic               out_abort_reg;
    logic               out_war_reg;
    logic               out_raw_reg;
    logic               out_last_reg;

    logic               abort_next;
    logic               war_next;
    logic               raw_next;
    logic               o_abort;
    logic               o_war;
    logic               o_raw;
    logic               w_we;
    logic               r_we;
    logic [ID_BITS-1:0] w_wd;
    logic [ID_BITS-1:0] r_wd;
    logic [IDX_W-1:0]   wr_addr;
    logic [ROW_W-1:0]   rem;

    // row modulo ROWS by restoring compare-subtract on the 10-bit index;
    // steps whose shifted divisor exceeds the index range drop out
    always_comb
    begin
        rem = row_reg;
        for (int k = ROW_W - 1; k >= 0; k--)
        begin
            if ((64'(ROWS) << k) <= 64'((1 << ROW_W) - 1))
            begin
                if (64'(rem) >= (64'(ROWS) << k))
                begin
                    rem = ROW_W'(64'(rem) - (64'(ROWS) << k));
                end
            end
        end
        row_red = IDX_W'(rem);
    end

    assign sts.clr_last = (clr_cnt_reg == IDX_W'(ROWS - 1));

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg   <= command;
            row_reg   <= row_index;
            wr_reg    <= is_write;
            id_reg    <= ID_BITS'(txn_id);
            first_reg <= first_access;
            last_reg  <= last_access;
        end
        if (ctl.lookup)
        begin
            addr_reg <= row_red;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (ctl.clear)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    // per-access update
    always_comb
    begin
        abort_next = abort_reg;
        war_next   = war_reg;
        raw_next   = raw_reg;
        w_we       = 1'b0;
        r_we       = 1'b0;
        w_wd       = id_reg;
        r_wd       = id_reg;
        o_abort    = 1'b0;
        o_war      = 1'b0;
        o_raw      = 1'b0;

        if (first_reg && (cmd_reg inside {CMD_RESERVE, CMD_CHECK, CMD_RELEASE}))
        begin
            abort_next = 1'b0;
            if (cmd_reg == CMD_CHECK)
            begin
                war_next = 1'b0;
                raw_next = 1'b0;
            end
        end

        case (cmd_reg)
            CMD_RESERVE:
            begin
                if (wr_reg)
                begin
                    if (wr_rd_reg > id_reg)
                    begin
                        w_we = 1'b1;
                    end
                    else
                    begin
                        abort_next = 1'b1;
                    end
                end
                else if (rd_rd_reg > id_reg)
                begin
                    r_we = 1'b1;
                end
                o_abort = abort_next;
            end
            CMD_CHECK:
            begin
                if (!abort_next)
                begin
                    if (wr_reg)
                    begin
                        if (wr_rd_reg < id_reg)
                        begin
                            abort_next = 1'b1;
                        end
                        else if (rd_rd_reg < id_reg)
                        begin
                            war_next = 1'b1;
                        end
                    end
                    else if (wr_rd_reg < id_reg)
                    begin
                        raw_next = 1'b1;
                    end
                    if (!abort_next && war_next && raw_next)
                    begin
                        abort_next = 1'b1;
                    end
                end
                o_abort = abort_next;
                o_war   = war_next;
                o_raw   = raw_next;
            end
            CMD_RELEASE:
            begin
                w_wd = FREE_ID;
                r_wd = FREE_ID;
                if (wr_reg)
                begin
                    w_we = (wr_rd_reg == id_reg);
                end
                else
                begin
                    r_we = (rd_rd_reg == id_reg);
                end
                o_abort = abort_next;
            end
            default:
            begin
                o_abort = 1'b0;
            end
        endcase

        if (ctl.clear)
        begin
            w_wd = FREE_ID;
            r_wd = FREE_ID;
        end
    end

    assign wr_addr = ctl.clear ? clr_cnt_reg : addr_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.clear || (ctl.exec && w_we))
        begin
            writer_mem[wr_addr] <= w_wd;
        end
        if (ctl.clear || (ctl.exec && r_we))
        begin
            reader_mem[wr_addr] <= r_wd;
        end
        wr_rd_reg <= writer_mem[row_red];
        rd_rd_reg <= reader_mem[row_red];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            abort_reg <= 1'b0;
            war_reg   <= 1'b0;
            raw_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= ctl.exec;
            if (ctl.exec)
            begin
                abort_reg <= abort_next;
                war_reg   <= war_next;
                raw_reg   <= raw_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.exec)
        begin
            out_abort_reg <= o_abort;
            out_war_reg   <= o_war;
            out_raw_reg   <= o_raw;
            out_last_reg  <= last_reg;
        end
    end

    assign done      = done_reg;
    assign aborted   = out_abort_reg;
    assign war_found = out_war_reg;
    assign raw_found = out_raw_reg;
    assign pass_done = out_last_reg;

endmodule

// ----- rtl/row_reservation_conflict_check_unit.sv -----
// Row reservation conflict check: one access per start, result on done.
// After the accepting edge an access passes lookup, update and result before done.
// A new access is accepted only in idle, after the table read-modify-write of the last.
// Reset: rst_n async; after release busy stays high while the tables are swept
// to the free value. Results cannot be stalled by the receiver.
module row_reservation_conflict_check_unit #(
    parameter int ROWS    = rrc_pkg::ROWS_DEF,
    parameter int ID_BITS = rrc_pkg::ID_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [rrc_pkg::CMD_W-1:0] command,
    input  logic [rrc_pkg::ROW_W-1:0] row_index,
    input  logic                      is_write,
    input  logic [rrc_pkg::TXN_W-1:0] txn_id,
    input  logic                      first_access,
    input  logic                      last_access,
    output logic                      done,
    output logic                      aborted,
    output logic                      war_found,
    output logic                      raw_found,
    output logic                      pass_done
);
    import rrc_pkg::*;

    ctl_t ctl;
    sts_t sts;

    rrc_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .ctl   (ctl),
        .busy  (busy)
    );

    rrc_datapath #(
        .ROWS    (ROWS),
        .ID_BITS (ID_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .sts          (sts),
        .command      (command),
        .row_index    (row_index),
        .is_write     (is_write),
        .txn_id       (txn_id),
        .first_access (first_access),
        .last_access  (last_access),
        .done         (done),
        .aborted      (aborted),
        .war_found    (war_found),
        .raw_found    (raw_found),
        .pass_done    (pass_done)
    );

`ifndef SYNTH
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !done))
        else $error("accepted transaction did not raise busy");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result issued while busy");

    a_done_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without preceding work cycle");

    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held two cycles");
`endif

endmodule

// ----- test/row_reservation_conflict_check_unit_tb.sv -----
// Testbench for row_reservation_conflict_check_unit: directed and random reserve/check/release
// passes, checked against an in-bench model of the reservation tables and pass flags.
// Depends on rrc_pkg and the top-level RTL only.
module row_reservation_conflict_check_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rrc_pkg::*;

    localparam int                NUM_ROWS   = ROWS_DEF;
    localparam logic [CMD_W-1:0]  CMD_UNUSED = 2'd3;
    localparam logic [TXN_W-1:0]  FREE_ID    = '1;
    localparam logic [TXN_W-1:0]  TOP_ID     = 32'hFFFF_FFFE;
    localparam int                MAX_REPORT = 10;

    typedef struct packed {
        logic aborted;
        logic war;
        logic raw;
        logic pass_end;
    } verdict_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic [CMD_W-1:0]  command;
    logic [ROW_W-1:0]  row_index;
    logic              is_write;
    logic [TXN_W-1:0]  txn_id;
    logic              first_access;
    logic              last_access;
    logic              done;
    logic              aborted;
    logic              war_found;
    logic              raw_found;
    logic              pass_done;

    row_reservation_conflict_check_unit uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .command      (command),
        .row_index    (row_index),
        .is_write     (is_write),
        .txn_id       (txn_id),
        .first_access (first_access),
        .last_access  (last_access),
        .done         (done),
        .aborted      (aborted),
        .war_found    (war_found),
        .raw_found    (raw_found),
        .pass_done    (pass_done)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // model state
    logic [TXN_W-1:0] writer_ids [NUM_ROWS];
    logic [TXN_W-1:0] reader_ids [NUM_ROWS];
    logic             war_seen;
    logic             raw_seen;
    logic             abort_seen;

    verdict_t pending_verdicts [$];

    int  sent_count;
    int  verdict_count;
    int  error_count;
    int  abort_count;
    int  hazard_count;
    bit  gaps_on;

    // current batch of transactions for the random passes
    logic [TXN_W-1:0] batch_id   [4];
    int               batch_len  [4];
    logic [ROW_W-1:0] batch_row  [4][4];
    logic             batch_wr   [4][4];

    function automatic verdict_t apply_access(
        input logic [CMD_W-1:0] cmd,
        input logic [ROW_W-1:0] row,
        input logic             wr,
        input logic [TXN_W-1:0] id,
        input logic             first,
        input logic             last
    );
        verdict_t v;
        v = '0;
        if (cmd != CMD_UNUSED && first)
        begin
            abort_seen = 1'b0;
            if (cmd == CMD_CHECK)
            begin
                war_seen = 1'b0;
                raw_seen = 1'b0;
            end
        end
        case (cmd)
            CMD_RESERVE:
            begin
                if (wr)
                begin
                    if (writer_ids[row] > id)
                        writer_ids[row] = id;
                    else
                        abort_seen = 1'b1;
                end
                else if (reader_ids[row] > id)
                    reader_ids[row] = id;
                v.aborted = abort_seen;
            end
            CMD_CHECK:
            begin
                // once aborted, the rest of the check pass is frozen
                if (!abort_seen)
                begin
                    if (wr)
                    begin
                        if (writer_ids[row] < id)
                            abort_seen = 1'b1;
                        else if (reader_ids[row] < id)
                            war_seen = 1'b1;
                    end
                    else if (writer_ids[row] < id)
                        raw_seen = 1'b1;
                    if (!abort_seen && war_seen && raw_seen)
                        abort_seen = 1'b1;
                end
                v.aborted = abort_seen;
                v.war     = war_seen;
                v.raw     = raw_seen;
            end
            CMD_RELEASE:
            begin
                if (wr)
                begin
                    if (writer_ids[row] == id)
                        writer_ids[row] = FREE_ID;
                end
                else if (reader_ids[row] == id)
                    reader_ids[row] = FREE_ID;
                v.aborted = abort_seen;
            end
            default: ;
        endcase
        v.pass_end = last;
        return v;
    endfunction

    task automatic idle_cycles(input int n);
        repeat (n)
        begin
            @(negedge clk);
            start = 1'b0;
        end
    endtask

    // one transaction on the command port; start stays high until the caller idles
    task automatic send_access(
        input logic [CMD_W-1:0] cmd,
        input logic [ROW_W-1:0] row,
        input logic             wr,
        input logic [TXN_W-1:0] id,
        input logic             first,
        input logic             last
    );
        if (gaps_on && $urandom_range(0, 4) == 0)
            idle_cycles($urandom_range(1, 8));
        @(negedge clk);
        start        = 1'b1;
        command      = cmd;
        row_index    = row;
        is_write     = wr;
        txn_id       = id;
        first_access = first;
        last_access  = last;
        do
            @(posedge clk);
        while (busy);
        pending_verdicts.push_back(apply_access(cmd, row, wr, id, first, last));
        sent_count++;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        start = 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
    endtask

    task automatic note_error(input string msg);
        error_count++;
        if (error_count <= MAX_REPORT)
            $display("[%0t] ERROR: %s", $realtime, msg);
    endtask

    verdict_t want_v;
    verdict_t got_v;

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            got_v = {aborted, war_found, raw_found, pass_done};
            if (pending_verdicts.size() == 0)
                note_error($sformatf("unexpected result abt=%b war=%b raw=%b end=%b",
                                     got_v.aborted, got_v.war, got_v.raw, got_v.pass_end));
            else
            begin
                want_v = pending_verdicts.pop_front();
                verdict_count++;
                if (want_v.aborted)
                    abort_count++;
                if (want_v.war || want_v.raw)
                    hazard_count++;
                if (got_v !== want_v)
                    note_error($sformatf(
                        "result %0d: expected abt=%b war=%b raw=%b end=%b, got %b %b %b %b",
                        verdict_count, want_v.aborted, want_v.war, want_v.raw,
                        want_v.pass_end, got_v.aborted, got_v.war, got_v.raw,
                        got_v.pass_end));
            end
        end
    end

    task automatic test_reserve_edges();
        send_access(CMD_RESERVE, 10'd0,    1'b1, 32'd0,   1'b1, 1'b1);
        send_access(CMD_RESERVE, 10'd0,    1'b1, 32'd5,   1'b1, 1'b1); // lower writer held
        send_access(CMD_RESERVE, 10'd1023, 1'b0, TOP_ID,  1'b1, 1'b0);
        send_access(CMD_RESERVE, 10'd1023, 1'b1, FREE_ID, 1'b0, 1'b1); // free id never wins
        send_access(CMD_RESERVE, 10'd0,    1'b1, 32'd3,   1'b1, 1'b0);
        send_access(CMD_RESERVE, 10'd2,    1'b0, 32'd3,   1'b0, 1'b1); // still reserves
        send_access(CMD_RESERVE, 10'd5,    1'b0, 32'd1,   1'b1, 1'b1);
    endtask

    task automatic test_check_hazards();
        send_access(CMD_CHECK, 10'd2,    1'b1, 32'd3, 1'b1, 1'b0);
        send_access(CMD_CHECK, 10'd0,    1'b0, 32'd3, 1'b0, 1'b0); // raw
        send_access(CMD_CHECK, 10'd5,    1'b1, 32'd3, 1'b0, 1'b0); // war -> abort
        send_access(CMD_CHECK, 10'd0,    1'b1, 32'd3, 1'b0, 1'b0);
        send_access(CMD_CHECK, 10'd1023, 1'b1, 32'd3, 1'b0, 1'b1);
        send_access(CMD_CHECK, 10'd0,    1'b1, 32'd9, 1'b1, 1'b1); // lower writer
        send_access(CMD_CHECK, 10'd5,    1'b1, 32'd4, 1'b1, 1'b1); // war alone
        wait_drained();
    endtask

    task automatic test_release_and_unused();
        send_access(CMD_RELEASE, 10'd0,    1'b1, 32'd0,   1'b1, 1'b0);
        send_access(CMD_RELEASE, 10'd5,    1'b0, 32'd2,   1'b0, 1'b0);
        send_access(CMD_RELEASE, 10'd5,    1'b0, 32'd1,   1'b0, 1'b1);
        send_access(CMD_RELEASE, 10'd1,    1'b1, FREE_ID, 1'b1, 1'b1);
        send_access(CMD_UNUSED,  10'd1023, 1'b1, FREE_ID, 1'b1, 1'b1);
        send_access(CMD_UNUSED,  10'd0,    1'b0, 32'd0,   1'b0, 1'b0);
        send_access(CMD_CHECK,   10'd0,    1'b1, 32'd9,   1'b1, 1'b1);
    endtask

    function automatic logic [TXN_W-1:0] pick_id();
        case ($urandom_range(0, 9))
            0:       return 32'd0;
            1:       return TOP_ID;
            2:       return $urandom();
            default: return 32'h8000_0000 + $urandom_range(0, 15);
        endcase
    endfunction

    task automatic send_noise();
        send_access(CMD_W'($urandom_range(0, 3)), ROW_W'($urandom_range(0, NUM_ROWS - 1)),
                    1'($urandom_range(0, 1)),
                    ($urandom_range(0, 15) == 0) ? FREE_ID : $urandom(),
                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    task automatic issue_pass(input logic [CMD_W-1:0] cmd, input int t);
        for (int a = 0; a < batch_len[t]; a++)
        begin
            if ($urandom_range(0, 19) == 0)
                send_noise();
            send_access(cmd, batch_row[t][a], batch_wr[t][a], batch_id[t],
                        a == 0, a == batch_len[t] - 1);
        end
    endtask

    // reserve phase, check phase, release phase over a batch of transactions
    task automatic run_batch();
        int txns;
        bit wide;
        txns = $urandom_range(1, 4);
        wide = ($urandom_range(0, 7) == 0);
        for (int t = 0; t < txns; t++)
        begin
            batch_id[t]  = pick_id();
            batch_len[t] = $urandom_range(1, 4);
            for (int a = 0; a < 4; a++)
            begin
                batch_row[t][a] = wide ? ROW_W'($urandom_range(0, NUM_ROWS - 1))
                                       : ROW_W'($urandom_range(0, 7));
                batch_wr[t][a]  = 1'($urandom_range(0, 1));
            end
        end
        for (int t = 0; t < txns; t++)
            issue_pass(CMD_RESERVE, t);
        for (int t = 0; t < txns; t++)
            issue_pass(CMD_CHECK, t);
        for (int t = 0; t < txns; t++)
            if ($urandom_range(0, 5) != 0)
                issue_pass(CMD_RELEASE, t);
    endtask

    task automatic test_random_batches();
        while (sent_count < 420)
        begin
            gaps_on = ($urandom_range(0, 3) != 0);
            run_batch();
        end
        wait_drained();
    endtask

    task automatic test_back_to_back();
        gaps_on = 1'b0;
        while (sent_count < 550)
            run_batch();
    endtask

    initial
    begin
        rst_n        = 1'b0;
        start        = 1'b0;
        command      = CMD_RESERVE;
        row_index    = '0;
        is_write     = 1'b0;
        txn_id       = '0;
        first_access = 1'b0;
        last_access  = 1'b0;
        sent_count    = 0;
        verdict_count = 0;
        error_count   = 0;
        abort_count   = 0;
        hazard_count  = 0;
        gaps_on       = 1'b1;
        for (int r = 0; r < NUM_ROWS; r++)
        begin
            writer_ids[r] = FREE_ID;
            reader_ids[r] = FREE_ID;
        end
        war_seen   = 1'b0;
        raw_seen   = 1'b0;
        abort_seen = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reserve_edges();
        test_check_hazards();
        test_release_and_unused();
        test_random_batches();
        test_back_to_back();

        wait_drained();
        repeat (10) @(posedge clk);
        if (pending_verdicts.size() != 0)
            note_error($sformatf("%0d results never arrived", pending_verdicts.size()));

        $display("Sent %0d transactions, checked %0d results (%0d aborted, %0d with hazards).",
                 sent_count, verdict_count, abort_count, hazard_count);
        $display("Mismatches: %0d", error_count);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #3_000_000;
        $display("Timeout after %0d transactions sent", sent_count);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
